>>> src/rspm_pkg.sv
// shared constants and types for the rolling sum pattern matcher
package rspm_pkg;

  localparam int MAX_PATTERN   = 64;
  localparam int POSITION_BITS = 20;
  localparam int BYTE_W        = 8;
  localparam int INDEX_W       = 6;
  localparam int CFG_W         = 7;
  localparam int HASH_W        = 16;
  localparam int LEN_W         = $clog2(MAX_PATTERN + 1);
  localparam int ADDR_W        = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  typedef enum logic {
    MODE_PATTERN = 1'b0,
    MODE_TEXT    = 1'b1
  } mode_t;

  typedef struct packed {
    logic              pat_we;
    logic [ADDR_W-1:0] pat_addr;
    logic              pat_first;
    logic              shift;
    logic              clear;
    logic [BYTE_W-1:0] data;
  } match_ctl_t;

endpackage

>>> src/rspm_in_if.sv
// input item channel: valid, ready and the input fields
interface rspm_in_if;
  import rspm_pkg::*;

  logic               valid;
  logic               ready;
  logic               mode;
  logic [INDEX_W-1:0] pattern_index;
  logic [BYTE_W-1:0]  byte_value;
  logic               last_text;

  modport source (output valid, mode, pattern_index, byte_value, last_text, input ready);
  modport sink   (input valid, mode, pattern_index, byte_value, last_text, output ready);
endinterface

>>> src/rspm_out_if.sv
// result item channel: valid, ready and the result fields
interface rspm_out_if;
  import rspm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     is_end;
  logic                     match_found;
  logic [POSITION_BITS-1:0] start_position;
  logic                     last;

  modport source (output valid, is_end, match_found, start_position, last, input ready);
  modport sink   (input valid, is_end, match_found, start_position, last, output ready);
endinterface

>>> src/rspm_match.sv
// pattern store, aligned text window, rolling sums and parallel byte compare
module rspm_match import rspm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  match_ctl_t       ctl,
  input  logic [LEN_W-1:0] len,
  output logic             hit
);

  logic [BYTE_W-1:0]      pattern     [MAX_PATTERN];
  logic [BYTE_W-1:0]      window      [MAX_PATTERN];
  logic [BYTE_W-1:0]      window_next [MAX_PATTERN];
  logic [HASH_W-1:0]      pattern_sum;
  logic [HASH_W-1:0]      window_sum;
  logic [HASH_W-1:0]      window_sum_next;
  logic [LEN_W-1:0]       fill_count;
  logic [LEN_W-1:0]       fill_next;
  logic                   full;
  logic [MAX_PATTERN-1:0] lane_eq;

  // lane k holds the text byte that lines up with pattern byte k, newest at lane len-1
  always_comb begin
    full = (fill_count >= len);
    for (int k = 0; k < MAX_PATTERN - 1; k++) begin
      window_next[k] = window[k + 1];
      if (int'(len) == k + 1) begin
        window_next[k] = ctl.data;
      end
    end
    window_next[MAX_PATTERN-1] = window[MAX_PATTERN-1];
    if (int'(len) == MAX_PATTERN) begin
      window_next[MAX_PATTERN-1] = ctl.data;
    end
    window_sum_next = (full ? (window_sum - HASH_W'(window[0])) : window_sum)
                      + HASH_W'(ctl.data);
    fill_next = full ? fill_count : fill_count + 1'b1;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      lane_eq[k] = (k >= int'(len)) || (window_next[k] == pattern[k]);
    end
    hit = (fill_next >= len) && (window_sum_next == pattern_sum) && (&lane_eq);
  end

  always_ff @(posedge clk) begin
    if (ctl.pat_we) begin
      pattern[ctl.pat_addr] <= ctl.data;
    end
    if (ctl.shift) begin
      window <= window_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_sum <= '0;
    end else if (ctl.pat_we) begin
      pattern_sum <= ctl.pat_first ? HASH_W'(ctl.data) : pattern_sum + HASH_W'(ctl.data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      window_sum <= '0;
      fill_count <= '0;
    end else if (ctl.shift) begin
      window_sum <= window_sum_next;
      fill_count <= fill_next;
    end
  end

endmodule

>>> src/rolling_sum_pattern_matcher_core.sv
// top level of the rolling sum pattern matcher
// an input item passes the input register and then the result register before its result is offered
// throughput: one item per cycle while results are taken; an item with a match on the final text byte holds
// the input while its two results drain
// the full window compare and both sums are evaluated in the single stage after the input register
// reset: synchronous, clears pattern sum, per-text state and handshake state, length reads 1
module rolling_sum_pattern_matcher_core import rspm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  rspm_in_if.sink          items,
  rspm_out_if.source       results,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  logic [LEN_W-1:0]         len;
  logic                     s0_valid;
  logic                     s0_mode;
  logic [INDEX_W-1:0]       s0_index;
  logic [BYTE_W-1:0]        s0_byte;
  logic                     s0_last;
  logic [POSITION_BITS-1:0] position;
  logic                     any_match;
  logic                     m_pend;
  logic                     e_pend;
  logic [POSITION_BITS-1:0] res_pos;
  logic                     res_any;

  logic                     is_text;
  logic                     adv;
  logic                     pop;
  logic                     out_free;
  logic                     hit;
  logic                     text_hit;
  logic [POSITION_BITS-1:0] position_next;
  logic [POSITION_BITS-1:0] start;
  logic [LEN_W-1:0]         len_next;
  match_ctl_t               ctl;

  assign is_text  = (s0_mode == MODE_TEXT);
  assign pop      = results.valid && results.ready;
  assign out_free = !(m_pend || e_pend) || (pop && !(m_pend && e_pend));
  assign adv      = s0_valid && out_free;
  assign items.ready = !s0_valid || adv;
  assign text_hit = is_text && hit;

  always_comb begin
    ctl.pat_we    = adv && !is_text && (int'(s0_index) < MAX_PATTERN);
    ctl.pat_addr  = ADDR_W'(s0_index);
    ctl.pat_first = (s0_index == '0);
    ctl.shift     = adv && is_text;
    ctl.clear     = cfg_we || (adv && is_text && s0_last);
    ctl.data      = s0_byte;
  end

  always_comb begin
    if (cfg_wdata == '0) begin
      len_next = LEN_W'(1);
    end else if (int'(cfg_wdata) > MAX_PATTERN) begin
      len_next = LEN_W'(MAX_PATTERN);
    end else begin
      len_next = LEN_W'(cfg_wdata);
    end
    position_next = (position == POS_MAX) ? position : position + 1'b1;
    start         = position_next - POSITION_BITS'(len) + 1'b1;
  end

  rspm_match u_match (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .len (len),
    .hit (hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= LEN_W'(1);
    end else if (cfg_we) begin
      len <= len_next;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (items.ready) begin
      s0_valid <= items.valid;
    end
    if (items.valid && items.ready) begin
      s0_mode  <= items.mode;
      s0_index <= items.pattern_index;
      s0_byte  <= items.byte_value;
      s0_last  <= items.last_text;
    end
  end

  // per-text position and match flag
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      position  <= '0;
      any_match <= 1'b0;
    end else if (ctl.shift) begin
      position  <= position_next;
      any_match <= any_match || hit;
    end
  end

  // result register, match result goes out before the end result
  always_ff @(posedge clk) begin
    if (rst) begin
      m_pend <= 1'b0;
      e_pend <= 1'b0;
    end else if (adv) begin
      m_pend <= text_hit;
      e_pend <= is_text && s0_last;
    end else if (pop) begin
      if (m_pend) begin
        m_pend <= 1'b0;
      end else begin
        e_pend <= 1'b0;
      end
    end
    if (adv) begin
      res_pos <= start;
      res_any <= any_match || text_hit;
    end
  end

  assign results.valid          = m_pend || e_pend;
  assign results.is_end         = !m_pend;
  assign results.match_found    = m_pend || res_any;
  assign results.start_position = m_pend ? res_pos : '0;
  assign results.last           = !(m_pend && e_pend);

endmodule

>>> bench/testbench.sv
// testbench for the rolling sum pattern matcher: directed and random traffic checked against a predictor
`timescale 1ns / 100ps

module testbench;
  import rspm_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASES      = 10;

  typedef struct packed {
    mode_t              mode;
    logic [INDEX_W-1:0] slot;
    logic [BYTE_W-1:0]  data;
    logic               last_text;
  } scan_item_t;

  typedef struct packed {
    logic                     is_end;
    logic                     match_found;
    logic [POSITION_BITS-1:0] start_position;
    logic                     last;
  } match_result_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  rspm_in_if  items_if ();
  rspm_out_if results_if ();

  rolling_sum_pattern_matcher_core dut (
    .clk       (clk),
    .rst       (rst),
    .items     (items_if),
    .results   (results_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // predicted block state
  logic [BYTE_W-1:0]        pat_mem [MAX_PATTERN];
  logic [BYTE_W-1:0]        win_mem [MAX_PATTERN];
  logic [HASH_W-1:0]        pat_sum;
  logic [HASH_W-1:0]        win_sum;
  int                       win_fill;
  logic [POSITION_BITS-1:0] text_pos;
  logic                     seen_match;
  logic [CFG_W-1:0]         cur_len;

  // stimulus side view of the pattern store
  logic [BYTE_W-1:0] gen_pat [MAX_PATTERN];
  bit                pat_written [MAX_PATTERN];
  logic [BYTE_W-1:0] alphabet [2];

  scan_item_t    send_q[$];
  match_result_t expected_matches[$];

  int pushed_count;
  int accepted_count;
  int mismatch_count;
  int cycle_count;
  int src_gap;
  int sink_gap;
  int hold_req;
  int hold_left;
  bit allow_idle;
  bit in_fire;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = ~clk;
  end

  task automatic clear_text_state();
    for (int k = 0; k < MAX_PATTERN; k++) win_mem[k] = '0;
    win_sum    = '0;
    win_fill   = 0;
    text_pos   = '0;
    seen_match = 1'b0;
  endtask

  task automatic predict_matches(input mode_t mode_in, input logic [INDEX_W-1:0] slot,
                                 input logic [BYTE_W-1:0] data, input logic last_text);
    int            len;
    bit            hit;
    match_result_t r;
    if (mode_in == MODE_PATTERN) begin
      pat_mem[slot] = data;
      if (slot == 0) pat_sum = HASH_W'(data);
      else pat_sum = pat_sum + HASH_W'(data);
    end else begin
      len = (cur_len == 0) ? 1 : (cur_len > MAX_PATTERN) ? MAX_PATTERN : int'(cur_len);
      if (win_fill >= len) win_sum = win_sum - HASH_W'(win_mem[len-1]);
      else win_fill++;
      for (int k = MAX_PATTERN - 1; k > 0; k--) win_mem[k] = win_mem[k-1];
      win_mem[0] = data;
      win_sum = win_sum + HASH_W'(data);
      if (text_pos != POS_MAX) text_pos = text_pos + 1'b1;
      hit = (win_fill >= len) && (win_sum == pat_sum);
      for (int k = 0; k < len; k++) begin
        if (win_mem[len-1-k] != pat_mem[k]) hit = 0;
      end
      if (hit) begin
        seen_match       = 1'b1;
        r.is_end         = 1'b0;
        r.match_found    = 1'b1;
        r.start_position = text_pos - POSITION_BITS'(len) + 1'b1;
        r.last           = !last_text;
        expected_matches.insert(expected_matches.size(), r);
      end
      if (last_text) begin
        r.is_end         = 1'b1;
        r.match_found    = seen_match;
        r.start_position = '0;
        r.last           = 1'b1;
        expected_matches.insert(expected_matches.size(), r);
        clear_text_state();
      end
    end
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // input side: acceptance and prediction
  always @(posedge clk) begin
    in_fire = !rst && items_if.valid && items_if.ready;
    if (in_fire) begin
      accepted_count++;
      predict_matches(mode_t'(items_if.mode), items_if.pattern_index, items_if.byte_value,
                      items_if.last_text);
    end
  end

  // output side: compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    match_result_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else if (!rst && results_if.valid && results_if.ready) begin
      if (expected_matches.size() == 0) begin
        $error("unexpected result transaction: is_end %0d match_found %0d start %0d",
               results_if.is_end, results_if.match_found, results_if.start_position);
        mismatch_count++;
      end else begin
        want = expected_matches.pop_front();
        compare_field("is_end", want.is_end, results_if.is_end);
        compare_field("match_found", want.match_found, results_if.match_found);
        compare_field("start_position", want.start_position, results_if.start_position);
        compare_field("last", want.last, results_if.last);
      end
    end
  end

  // driver
  always @(negedge clk) begin
    scan_item_t nxt;
    if (!items_if.valid || in_fire) begin
      if (src_gap > 0) begin
        src_gap--;
        items_if.valid <= 1'b0;
      end else if (send_q.size() > 0) begin
        nxt = send_q.pop_front();
        items_if.valid         <= 1'b1;
        items_if.mode          <= nxt.mode;
        items_if.pattern_index <= nxt.slot;
        items_if.byte_value    <= nxt.data;
        items_if.last_text     <= nxt.last_text;
        if (allow_idle && $urandom_range(0, 4) == 0) src_gap = $urandom_range(1, 4);
      end else begin
        items_if.valid <= 1'b0;
      end
    end
  end

  // result ready with random stalls and the long hold-off
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      results_if.ready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      results_if.ready <= 1'b0;
    end else begin
      results_if.ready <= 1'b1;
      if (allow_idle && $urandom_range(0, 4) == 0) sink_gap = $urandom_range(1, 4);
    end
  end

  task automatic push_item(input mode_t mode_in, input logic [INDEX_W-1:0] slot,
                           input logic [BYTE_W-1:0] data, input logic last_text);
    scan_item_t it;
    it.mode      = mode_in;
    it.slot      = slot;
    it.data      = data;
    it.last_text = last_text;
    if (mode_in == MODE_PATTERN) begin
      gen_pat[slot]     = data;
      pat_written[slot] = 1'b1;
    end
    send_q.insert(send_q.size(), it);
    pushed_count++;
  endtask

  task automatic wait_idle();
    while (accepted_count != pushed_count || expected_matches.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_length(input logic [CFG_W-1:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    cur_len = value;
    clear_text_state();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [BYTE_W-1:0] pick_byte();
    if ($urandom_range(0, 7) == 0) return BYTE_W'($urandom);
    return alphabet[$urandom_range(0, 1)];
  endfunction

  task automatic load_pattern(input int len);
    for (int k = 0; k < len; k++) begin
      push_item(MODE_PATTERN, INDEX_W'(k), pick_byte(), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic send_text(input int len);
    logic [BYTE_W-1:0] bytes_q[$];
    int                target;
    if ($urandom_range(0, 5) == 0) target = $urandom_range(1, len);
    else target = $urandom_range(len, 3 * len + 6);
    while (bytes_q.size() < target) begin
      if ($urandom_range(0, 2) == 0) begin
        for (int k = 0; k < len; k++) bytes_q.insert(bytes_q.size(), gen_pat[k]);
      end else begin
        bytes_q.insert(bytes_q.size(), pick_byte());
      end
    end
    foreach (bytes_q[k]) begin
      push_item(MODE_TEXT, INDEX_W'($urandom_range(0, MAX_PATTERN - 1)), bytes_q[k],
                k == bytes_q.size() - 1);
    end
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] value, input int budget,
                           input bit idle_on, input bit long_hold);
    int len;
    int start;
    bit need_load;
    set_length(value);
    allow_idle  = idle_on;
    alphabet[0] = BYTE_W'($urandom);
    alphabet[1] = BYTE_W'($urandom);
    if (long_hold) hold_req = 150;
    len = (value == 0) ? 1 : (value > MAX_PATTERN) ? MAX_PATTERN : int'(value);
    need_load = 1'b0;
    for (int k = 0; k < len; k++) begin
      if (!pat_written[k]) need_load = 1'b1;
    end
    if (need_load || $urandom_range(0, 3) != 0) load_pattern(len);
    start = pushed_count;
    while (pushed_count - start < budget) begin
      if ($urandom_range(0, 9) == 0) begin
        push_item(MODE_PATTERN, INDEX_W'($urandom_range(0, MAX_PATTERN - 1)),
                  BYTE_W'($urandom), 1'($urandom_range(0, 1)));
      end else if ($urandom_range(0, 7) == 0) begin
        load_pattern(len);
      end
      send_text(len);
    end
  endtask

  initial begin
    logic [CFG_W-1:0] len_plan [PHASES];
    len_plan = '{7'd1, 7'd0, 7'd64, 7'd2, 7'd127, 7'd5, 7'd6, 7'd4, 7'd8, 7'd3};

    rst                    = 1'b1;
    cfg_we                 = 1'b0;
    cfg_wdata              = '0;
    items_if.valid         = 1'b0;
    items_if.mode          = MODE_PATTERN;
    items_if.pattern_index = '0;
    items_if.byte_value    = '0;
    items_if.last_text     = 1'b0;
    results_if.ready       = 1'b0;
    pushed_count   = 0;
    accepted_count = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    src_gap        = 0;
    sink_gap       = 0;
    hold_req       = 0;
    hold_left      = 0;
    allow_idle     = 1'b1;
    in_fire        = 1'b0;
    pat_sum        = '0;
    cur_len        = 7'd1;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      pat_mem[k]     = '0;
      gen_pat[k]     = '0;
      pat_written[k] = 1'b0;
    end
    clear_text_state();

    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // directed: three byte pattern with extreme bytes and both ends of the index range
    set_length(7'd3);
    push_item(MODE_PATTERN, 6'd63, 8'h55, 1'b1);
    push_item(MODE_PATTERN, 6'd0, 8'hff, 1'b0);
    push_item(MODE_PATTERN, 6'd1, 8'h00, 1'b0);
    push_item(MODE_PATTERN, 6'd2, 8'h80, 1'b1);
    // text shorter than the pattern
    push_item(MODE_TEXT, 6'd0, 8'hff, 1'b1);
    // same sum, different bytes
    push_item(MODE_TEXT, 6'd63, 8'h00, 1'b0);
    push_item(MODE_TEXT, 6'd0, 8'hff, 1'b0);
    push_item(MODE_TEXT, 6'd0, 8'h80, 1'b1);
    // match mid text, then a match on the final byte
    push_item(MODE_TEXT, 6'd0, 8'hff, 1'b0);
    push_item(MODE_TEXT, 6'd0, 8'h00, 1'b0);
    push_item(MODE_TEXT, 6'd0, 8'h80, 1'b0);
    push_item(MODE_TEXT, 6'd0, 8'hff, 1'b0);
    push_item(MODE_TEXT, 6'd0, 8'h00, 1'b0);
    push_item(MODE_TEXT, 6'd0, 8'h80, 1'b1);

    for (int p = 0; p < PHASES; p++) begin
      run_phase(len_plan[p], (len_plan[p] >= MAX_PATTERN) ? 1 : 20, p < PHASES - 2, p == 3);
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
